// File: hw/rtl/stsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared types, codes and constants of the separator token scanner.
// ----------------------------------------------------------------------------
package stsc_pkg;

  localparam int LEN_W           = 11;
  localparam int MAX_TOKEN_LEN_D = 1024;

  // Scanner modes.
  typedef enum logic [2:0] {
    M_SKIP    = 3'd0,
    M_SLASH   = 3'd1,
    M_COMMENT = 3'd2,
    M_QUOTE   = 3'd3,
    M_WORD    = 3'd4
  } mode_t;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOI  = 2'd2;

  // Token-end status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DISCARD = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SEP_A     = 3'd0;
  localparam logic [2:0] CFG_SEP_B     = 3'd1;
  localparam logic [2:0] CFG_SEP_C     = 3'd2;
  localparam logic [2:0] CFG_SEP_D     = 3'd3;
  localparam logic [2:0] CFG_SEP_COUNT = 3'd4;
  localparam logic [2:0] CFG_LIMIT     = 3'd5;

  // Special characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Register reset values.
  localparam logic [7:0]       RST_SEP_A     = 8'd32;
  localparam logic [7:0]       RST_SEP_B     = 8'd9;
  localparam logic [7:0]       RST_SEP_C     = 8'd10;
  localparam logic [7:0]       RST_SEP_D     = 8'd13;
  localparam logic [2:0]       RST_SEP_COUNT = 3'd4;
  localparam logic [LEN_W-1:0] RST_LIMIT     = 11'd1024;

  typedef struct packed {
    logic [7:0]       sep_a;
    logic [7:0]       sep_b;
    logic [7:0]       sep_c;
    logic [7:0]       sep_d;
    logic [2:0]       sep_count;
    logic [LEN_W-1:0] token_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic [1:0]       status;
    logic             quoted;
  } res_t;

  // Up to three results caused by one input byte.
  typedef struct packed {
    logic [1:0]      n;
    res_t [2:0]      res;
  } step_t;

  // Token counter width: enough for the clamped limit, never wider than the
  // length field.
  function automatic int cnt_width(input int max_len);
    int w;
    begin
      w = $clog2(max_len + 1);
      return (w > LEN_W) ? LEN_W : w;
    end
  endfunction

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                  input logic [LEN_W-1:0] len,
                                  input logic [1:0] status, input logic quoted);
    res_t r;
    begin
      r.kind   = kind;
      r.data   = data;
      r.len    = len;
      r.status = status;
      r.quoted = quoted;
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/stsc_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stsc_decode
// Per-byte scanner step: classifies one byte against the current mode and
// produces up to three results together with the next mode and count.
// ----------------------------------------------------------------------------
module stsc_decode #(
  parameter int MAX_TOKEN_LEN = stsc_pkg::MAX_TOKEN_LEN_D,
  localparam int CNT_W = stsc_pkg::cnt_width(MAX_TOKEN_LEN)
) (
  input  var stsc_pkg::cfg_t  cfg,
  input  var stsc_pkg::mode_t mode,
  input  wire [CNT_W-1:0]     cnt,
  input  wire [7:0]           ch,
  output stsc_pkg::step_t     step,
  output stsc_pkg::mode_t     mode_nxt,
  output logic [CNT_W-1:0]    cnt_nxt
);

  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] lim_m1;
  logic [2:0]       nsep;
  logic             is_sep;

  // Effective limit: zero acts as one, anything above the maximum is clamped.
  always_comb begin
    if (cfg.token_limit == '0) begin
      lim = CNT_W'(1);
    end else if (32'(cfg.token_limit) > 32'(MAX_TOKEN_LEN)) begin
      lim = CNT_W'(MAX_TOKEN_LEN);
    end else begin
      lim = CNT_W'(cfg.token_limit);
    end
  end

  assign lim_m1 = lim - CNT_W'(1);
  assign nsep   = (cfg.sep_count > 3'd4) ? 3'd4 : cfg.sep_count;
  assign is_sep = (ch == stsc_pkg::CH_NUL)
               || ((nsep > 3'd0) && (ch == cfg.sep_a))
               || ((nsep > 3'd1) && (ch == cfg.sep_b))
               || ((nsep > 3'd2) && (ch == cfg.sep_c))
               || ((nsep > 3'd3) && (ch == cfg.sep_d));

  logic [CNT_W-1:0] c_v;
  logic [1:0]       k;
  logic             do_word;
  logic             do_start;

  always_comb begin
    step     = '0;
    c_v      = cnt;
    mode_nxt = mode;
    k        = '0;
    do_word  = 1'b0;
    do_start = 1'b0;

    unique case (mode)
      stsc_pkg::M_SLASH: begin
        if (ch == stsc_pkg::CH_SLASH) begin
          mode_nxt = stsc_pkg::M_COMMENT;
        end else begin
          // A lone slash opens a word; the current byte is then scanned within it.
          mode_nxt = stsc_pkg::M_WORD;
          c_v      = '0;
          if (c_v < lim) begin
            step.res[k] = stsc_pkg::mk_res(stsc_pkg::KIND_BYTE, stsc_pkg::CH_SLASH,
                                           '0, stsc_pkg::ST_OK, 1'b0);
            k   = k + 2'd1;
            c_v = c_v + CNT_W'(1);
          end
          do_word = 1'b1;
        end
      end
      stsc_pkg::M_COMMENT: begin
        if (ch == stsc_pkg::CH_NUL || ch == stsc_pkg::CH_NL) begin
          do_start = 1'b1;
        end
      end
      stsc_pkg::M_QUOTE: begin
        if (ch == stsc_pkg::CH_QUOTE || ch == stsc_pkg::CH_NUL) begin
          step.res[k] = stsc_pkg::mk_res(stsc_pkg::KIND_END, 8'h00,
                          stsc_pkg::LEN_W'((c_v < lim_m1) ? c_v : lim_m1),
                          (c_v > lim_m1) ? stsc_pkg::ST_TRUNC : stsc_pkg::ST_OK,
                          1'b1);
          k        = k + 2'd1;
          c_v      = '0;
          mode_nxt = stsc_pkg::M_SKIP;
          if (ch == stsc_pkg::CH_NUL) begin
            step.res[k] = stsc_pkg::mk_res(stsc_pkg::KIND_EOI, 8'h00, '0,
                                           stsc_pkg::ST_OK, 1'b0);
            k = k + 2'd1;
          end
        end else if (c_v < lim) begin
          step.res[k] = stsc_pkg::mk_res(stsc_pkg::KIND_BYTE, ch, '0,
                                         stsc_pkg::ST_OK, 1'b0);
          k   = k + 2'd1;
          c_v = c_v + CNT_W'(1);
        end
      end
      stsc_pkg::M_WORD: begin
        do_word = 1'b1;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    if (do_word) begin
      if (is_sep) begin
        // A word that filled the buffer is thrown away.
        if (c_v >= lim) begin
          step.res[k] = stsc_pkg::mk_res(stsc_pkg::KIND_END, 8'h00, '0,
                                         stsc_pkg::ST_DISCARD, 1'b0);
        end else begin
          step.res[k] = stsc_pkg::mk_res(stsc_pkg::KIND_END, 8'h00,
                                         stsc_pkg::LEN_W'(c_v),
                                         stsc_pkg::ST_OK, 1'b0);
        end
        k        = k + 2'd1;
        c_v      = '0;
        do_start = 1'b1;
      end else if (c_v < lim) begin
        step.res[k] = stsc_pkg::mk_res(stsc_pkg::KIND_BYTE, ch, '0,
                                       stsc_pkg::ST_OK, 1'b0);
        k   = k + 2'd1;
        c_v = c_v + CNT_W'(1);
      end
    end

    if (do_start) begin
      if (is_sep) begin
        mode_nxt = stsc_pkg::M_SKIP;
        if (ch == stsc_pkg::CH_NUL) begin
          c_v         = '0;
          step.res[k] = stsc_pkg::mk_res(stsc_pkg::KIND_EOI, 8'h00, '0,
                                         stsc_pkg::ST_OK, 1'b0);
          k           = k + 2'd1;
        end
      end else if (ch == stsc_pkg::CH_SLASH) begin
        mode_nxt = stsc_pkg::M_SLASH;
      end else if (ch == stsc_pkg::CH_QUOTE) begin
        mode_nxt = stsc_pkg::M_QUOTE;
        c_v      = '0;
      end else begin
        mode_nxt = stsc_pkg::M_WORD;
        c_v      = '0;
        if (c_v < lim) begin
          step.res[k] = stsc_pkg::mk_res(stsc_pkg::KIND_BYTE, ch, '0,
                                         stsc_pkg::ST_OK, 1'b0);
          k   = k + 2'd1;
          c_v = c_v + CNT_W'(1);
        end
      end
    end

    step.n  = k;
    cnt_nxt = c_v;
  end

endmodule
`default_nettype wire

// File: hw/rtl/stsc_rbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stsc_rbuf
// Result register: holds the results of one byte and presents them on the
// output channel one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module stsc_rbuf (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       load,
  input  var stsc_pkg::step_t       step,
  output logic                      free,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_out_byte,
  output logic [stsc_pkg::LEN_W-1:0] out_token_len,
  output logic [1:0]                out_status,
  output logic                      out_was_quoted,
  output logic                      out_last
);

  stsc_pkg::res_t [2:0] res_r;
  logic [1:0]           cnt_r;
  logic [1:0]           idx_r;
  stsc_pkg::res_t       cur;
  logic                 out_fire;

  always_comb begin
    case (idx_r)
      2'd1:    cur = res_r[1];
      2'd2:    cur = res_r[2];
      default: cur = res_r[0];
    endcase
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_last       = ((idx_r + 2'd1) == cnt_r);
  assign out_fire       = out_valid && !out_stall;
  assign free           = !out_valid || (out_fire && out_last);
  assign out_kind       = cur.kind;
  assign out_out_byte   = cur.data;
  assign out_token_len  = cur.len;
  assign out_status     = cur.status;
  assign out_was_quoted = cur.quoted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= step.n;
      idx_r <= 2'd0;
    end else if (out_fire) begin
      if (out_last) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= step.res;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/separator_token_scanner_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// separator_token_scanner_core
// Splits a byte stream into words, quoted strings and skipped comments,
// emitting token bytes and token-end results.
// ----------------------------------------------------------------------------
// A request is registered on acceptance, then decoded into the result register
// once it is free, from which its first result is offered. Throughput: one byte
// per cycle while out_stall is low and each byte gives at most one result; a
// byte with more holds the single result port until all of them are taken.
// Reset (synchronous, rst_n low): scanner skips separators, count zero,
// registers take their defaults, input and result registers empty.
module separator_token_scanner_core #(
  parameter int MAX_TOKEN_LEN = stsc_pkg::MAX_TOKEN_LEN_D
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [7:0]                  in_ch,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_out_byte,
  output logic [stsc_pkg::LEN_W-1:0] out_token_len,
  output logic [1:0]                 out_status,
  output logic                       out_was_quoted,
  output logic                       out_last,
  input  wire                        cfg_we,
  input  wire [2:0]                  cfg_index,
  input  wire [stsc_pkg::LEN_W-1:0]  cfg_wdata
);

  localparam int CNT_W = stsc_pkg::cnt_width(MAX_TOKEN_LEN);

  stsc_pkg::cfg_t   cfg_r;
  stsc_pkg::mode_t  mode_r;
  stsc_pkg::mode_t  mode_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             in_valid_r;
  logic [7:0]       in_ch_r;
  logic             buf_free;
  logic             proc;
  stsc_pkg::step_t  step;

  // The buffered request moves on once the result register can take it.
  assign proc     = in_valid_r && buf_free;
  assign in_stall = in_valid_r && !buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_ch_r <= in_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= stsc_pkg::M_SKIP;
      count_r <= '0;
    end else if (proc) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sep_a       <= stsc_pkg::RST_SEP_A;
      cfg_r.sep_b       <= stsc_pkg::RST_SEP_B;
      cfg_r.sep_c       <= stsc_pkg::RST_SEP_C;
      cfg_r.sep_d       <= stsc_pkg::RST_SEP_D;
      cfg_r.sep_count   <= stsc_pkg::RST_SEP_COUNT;
      cfg_r.token_limit <= stsc_pkg::RST_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stsc_pkg::CFG_SEP_A:     cfg_r.sep_a       <= cfg_wdata[7:0];
        stsc_pkg::CFG_SEP_B:     cfg_r.sep_b       <= cfg_wdata[7:0];
        stsc_pkg::CFG_SEP_C:     cfg_r.sep_c       <= cfg_wdata[7:0];
        stsc_pkg::CFG_SEP_D:     cfg_r.sep_d       <= cfg_wdata[7:0];
        stsc_pkg::CFG_SEP_COUNT: cfg_r.sep_count   <= cfg_wdata[2:0];
        stsc_pkg::CFG_LIMIT:     cfg_r.token_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  stsc_decode #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_decode (
    .cfg      (cfg_r),
    .mode     (mode_r),
    .cnt      (count_r),
    .ch       (in_ch_r),
    .step     (step),
    .mode_nxt (mode_nxt),
    .cnt_nxt  (count_nxt)
  );

  stsc_rbuf u_rbuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (proc),
    .step           (step),
    .free           (buf_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_out_byte   (out_out_byte),
    .out_token_len  (out_token_len),
    .out_status     (out_status),
    .out_was_quoted (out_was_quoted),
    .out_last       (out_last)
  );

  // End of input is always the final result of its byte.
  a_eoi_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == stsc_pkg::KIND_EOI) |-> out_last)
    else $error("end-of-input result not marked last");

  // A taken result that is not the last one is followed by another.
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("results of a byte lost after a non-last result");

  // Token bytes carry no length, status or quote flag.
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == stsc_pkg::KIND_BYTE) |->
      (out_token_len == '0 && out_status == stsc_pkg::ST_OK && !out_was_quoted))
    else $error("token byte result with token-end fields set");

endmodule
`default_nettype wire
